// ===== hdl/mmt_pkg.sv =====
`timescale 1ns / 1ps
package mmt_pkg;
	localparam int DEF_MAX_DIM   = 8;
	localparam int DEF_ELEM_BITS = 16;
	localparam int SUM_W         = 35;
	localparam int RESULT_LIMIT  = 64;
	localparam int DIM_W         = 4;
	localparam int CFG_IDX_W     = 3;

	localparam logic [1:0] CMD_LOAD_L = 2'd0;
	localparam logic [1:0] CMD_LOAD_R = 2'd1;
	localparam logic [1:0] CMD_START  = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_LEFT_ROWS  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LEFT_COLS  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_RIGHT_ROWS = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_RIGHT_COLS = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_TRANS_L    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_TRANS_R    = 3'd5;

	// One result element on its way down the chain.
	typedef struct packed {
		logic                    valid;
		logic [DIM_W-1:0]        i;
		logic [DIM_W-1:0]        j;
		logic                    last;
		logic                    err;
		logic signed [SUM_W-1:0] sum;
	} token_t;

	// Element write broadcast to every cell.
	typedef struct packed {
		logic        load_l;
		logic        load_r;
		logic [2:0]  r;
		logic [2:0]  c;
		logic [15:0] value;
	} ld_t;

	typedef struct packed {
		logic             trans_l;
		logic             trans_r;
		logic [DIM_W-1:0] k;
	} cell_cfg_t;
endpackage

// ===== hdl/mmt_cell.sv =====
`timescale 1ns / 1ps
module mmt_cell #(
	parameter int MAX_DIM   = mmt_pkg::DEF_MAX_DIM,
	parameter int ELEM_BITS = mmt_pkg::DEF_ELEM_BITS,
	parameter int IDX       = 0
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               advance,
	input  mmt_pkg::cell_cfg_t cfg,
	input  mmt_pkg::ld_t       ld,
	input  mmt_pkg::token_t    tok_in,
	output mmt_pkg::token_t    tok_out
);
	localparam int IW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
	localparam int PW = 2 * ELEM_BITS;
	localparam int SW = mmt_pkg::SUM_W;

	// Cell t keeps row t and column t of both matrices, so every operand of
	// inner index t is local whichever transposes are selected.
	logic signed [ELEM_BITS-1:0] row_l_q [MAX_DIM];
	logic signed [ELEM_BITS-1:0] col_l_q [MAX_DIM];
	logic signed [ELEM_BITS-1:0] row_r_q [MAX_DIM];
	logic signed [ELEM_BITS-1:0] col_r_q [MAX_DIM];

	logic [ELEM_BITS+15:0]       vx;
	logic [ELEM_BITS-1:0]        v;
	logic [IW-1:0]               ri, ci, ii, ji;
	logic                        r_hit, c_hit, en;
	logic signed [ELEM_BITS-1:0] lop, rop;
	logic signed [PW-1:0]        prod;
	logic [PW+SW-1:0]            px;
	logic signed [SW-1:0]        term;
	mmt_pkg::token_t             tok_q;

	assign vx    = {{ELEM_BITS{ld.value[15]}}, ld.value};
	assign v     = vx[ELEM_BITS-1:0];
	assign ri    = IW'(ld.r);
	assign ci    = IW'(ld.c);
	assign ii    = IW'(tok_in.i);
	assign ji    = IW'(tok_in.j);
	assign r_hit = (32'(ld.r) == IDX);
	assign c_hit = (32'(ld.c) == IDX);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int e = 0; e < MAX_DIM; e++) begin
				row_l_q[e] <= '0;
				col_l_q[e] <= '0;
				row_r_q[e] <= '0;
				col_r_q[e] <= '0;
			end
		end else begin
			if (ld.load_l && r_hit) row_l_q[ci] <= v;
			if (ld.load_l && c_hit) col_l_q[ri] <= v;
			if (ld.load_r && r_hit) row_r_q[ci] <= v;
			if (ld.load_r && c_hit) col_r_q[ri] <= v;
		end
	end

	assign lop  = cfg.trans_l ? row_l_q[ii] : col_l_q[ii];
	assign rop  = cfg.trans_r ? col_r_q[ji] : row_r_q[ji];
	assign prod = lop * rop;
	assign px   = {{SW{prod[PW-1]}}, prod};
	assign term = px[SW-1:0];
	assign en   = tok_in.valid && !tok_in.err && (IDX < 32'(cfg.k));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
		end else if (advance) begin
			tok_q.valid <= tok_in.valid;
			tok_q.i     <= tok_in.i;
			tok_q.j     <= tok_in.j;
			tok_q.last  <= tok_in.last;
			tok_q.err   <= tok_in.err;
			tok_q.sum   <= en ? tok_in.sum + term : tok_in.sum;
		end
	end

	assign tok_out = tok_q;
endmodule

// ===== hdl/matrix_multiply_with_transpose_top.sv =====
`timescale 1ns / 1ps
// Matrix multiply engine built as a chain of MAX_DIM multiply-accumulate
// cells, each holding one row and one column of both operand stores. A start
// injects one partial sum per result element into the chain; each passes
// through every cell and then the output register, and issue holds while
// the output stalls. A size error gives a single flagged result instead.
// Loads and starts are refused until the last result of a start has been
// transferred. Both stores are cleared by reset.
module matrix_multiply_with_transpose_top #(
	parameter int MAX_DIM   = mmt_pkg::DEF_MAX_DIM,
	parameter int ELEM_BITS = mmt_pkg::DEF_ELEM_BITS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,   // cmd[1:0], row[4:2], col[7:5], value[23:8]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [47:0] m_axis_tdata,   // out_row[2:0], out_col[5:3], sum[40:6], zeros
	output logic        m_axis_tlast,
	output logic        m_axis_tuser,   // error
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [3:0]  cfg_data
);
	localparam int DW = mmt_pkg::DIM_W;

	logic [DW-1:0] left_rows_q, left_cols_q, right_rows_q, right_cols_q;
	logic          trans_l_q, trans_r_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_rows_q  <= '0;
			left_cols_q  <= '0;
			right_rows_q <= '0;
			right_cols_q <= '0;
			trans_l_q    <= 1'b0;
			trans_r_q    <= 1'b0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				mmt_pkg::REG_LEFT_ROWS:  left_rows_q  <= cfg_data;
				mmt_pkg::REG_LEFT_COLS:  left_cols_q  <= cfg_data;
				mmt_pkg::REG_RIGHT_ROWS: right_rows_q <= cfg_data;
				mmt_pkg::REG_RIGHT_COLS: right_cols_q <= cfg_data;
				mmt_pkg::REG_TRANS_L:    trans_l_q    <= cfg_data[0];
				mmt_pkg::REG_TRANS_R:    trans_r_q    <= cfg_data[0];
				default: ;
			endcase
		end
	end

	logic [1:0]  cmd;
	logic [2:0]  row, col;
	logic [15:0] value;
	logic        accept;

	assign cmd   = s_axis_tdata[1:0];
	assign row   = s_axis_tdata[4:2];
	assign col   = s_axis_tdata[7:5];
	assign value = s_axis_tdata[23:8];

	logic busy_q, issuing_q, err_q;
	logic [DW-1:0] i_q, j_q, m_q, n_q, k_q;
	logic advance;

	assign s_axis_tready = !busy_q;
	assign accept        = s_axis_tvalid && s_axis_tready;

	logic              in_dim;
	mmt_pkg::ld_t      ld;

	assign in_dim    = (32'(row) < MAX_DIM) && (32'(col) < MAX_DIM);
	assign ld.load_l = accept && (cmd == mmt_pkg::CMD_LOAD_L) && in_dim &&
		({1'b0, row} < left_rows_q) && ({1'b0, col} < left_cols_q);
	assign ld.load_r = accept && (cmd == mmt_pkg::CMD_LOAD_R) && in_dim &&
		({1'b0, row} < right_rows_q) && ({1'b0, col} < right_cols_q);
	assign ld.r      = row;
	assign ld.c      = col;
	assign ld.value  = value;

	logic [DW-1:0]   m_d, k_d, kr_d, n_d;
	logic [2*DW-1:0] mn_d;
	logic            bad_d, start, last_issue;

	assign m_d  = trans_l_q ? left_cols_q : left_rows_q;
	assign k_d  = trans_l_q ? left_rows_q : left_cols_q;
	assign kr_d = trans_r_q ? right_cols_q : right_rows_q;
	assign n_d  = trans_r_q ? right_rows_q : right_cols_q;
	assign mn_d = (2*DW)'(m_d) * (2*DW)'(n_d);
	assign bad_d = (m_d == '0) || (k_d == '0) || (n_d == '0) || (k_d != kr_d) ||
		(32'(left_rows_q) > MAX_DIM) || (32'(left_cols_q) > MAX_DIM) ||
		(32'(right_rows_q) > MAX_DIM) || (32'(right_cols_q) > MAX_DIM) ||
		(32'(mn_d) > mmt_pkg::RESULT_LIMIT);
	assign start = accept && (cmd == mmt_pkg::CMD_START);
	assign last_issue = err_q || ((i_q == m_q - 1'b1) && (j_q == n_q - 1'b1));

	logic out_valid_q;
	mmt_pkg::token_t out_q;
	mmt_pkg::token_t chain [MAX_DIM+1];

	assign advance = !out_valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b0;
			issuing_q <= 1'b0;
			err_q     <= 1'b0;
			i_q       <= '0;
			j_q       <= '0;
			m_q       <= '0;
			n_q       <= '0;
			k_q       <= '0;
		end else begin
			if (start) begin
				busy_q    <= 1'b1;
				issuing_q <= 1'b1;
				err_q     <= bad_d;
				i_q       <= '0;
				j_q       <= '0;
				m_q       <= m_d;
				n_q       <= n_d;
				k_q       <= k_d;
			end else begin
				if (issuing_q && advance) begin
					if (last_issue) begin
						issuing_q <= 1'b0;
					end else if (j_q == n_q - 1'b1) begin
						j_q <= '0;
						i_q <= i_q + 1'b1;
					end else begin
						j_q <= j_q + 1'b1;
					end
				end
				if (m_axis_tvalid && m_axis_tready && m_axis_tlast) busy_q <= 1'b0;
			end
		end
	end

	assign chain[0].valid = issuing_q;
	assign chain[0].i     = err_q ? '0 : i_q;
	assign chain[0].j     = err_q ? '0 : j_q;
	assign chain[0].last  = last_issue;
	assign chain[0].err   = err_q;
	assign chain[0].sum   = '0;

	mmt_pkg::cell_cfg_t ccfg;
	assign ccfg.trans_l = trans_l_q;
	assign ccfg.trans_r = trans_r_q;
	assign ccfg.k       = k_q;

	for (genvar g = 0; g < MAX_DIM; g++) begin : g_cell
		mmt_cell #(
			.MAX_DIM   (MAX_DIM),
			.ELEM_BITS (ELEM_BITS),
			.IDX       (g)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.advance (advance),
			.cfg     (ccfg),
			.ld      (ld),
			.tok_in  (chain[g]),
			.tok_out (chain[g+1])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= chain[MAX_DIM].valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) out_q <= chain[MAX_DIM];
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {7'd0, out_q.sum, out_q.j[2:0], out_q.i[2:0]};
	assign m_axis_tlast  = out_q.last;
	assign m_axis_tuser  = out_q.err;

`ifndef SYNTH
	a_err_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |-> m_axis_tlast && (out_q.sum == '0))
		else $error("error result must be single and zero");
	a_issue_busy: assert property (@(posedge clk) disable iff (!arst_n)
		issuing_q |-> busy_q)
		else $error("issuing while idle");
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tready && m_axis_tlast |=> !busy_q)
		else $error("busy after final transfer");
	a_no_load_busy: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> !ld.load_l && !ld.load_r)
		else $error("store written during a multiply");
`endif
endmodule

// ===== test/mmt_checker.sv =====
`timescale 1ns / 1ps
module mmt_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic [47:0] m_axis_tdata,
	input  logic        m_axis_tlast,
	input  logic        m_axis_tuser,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [3:0]  cfg_data,
	output int          fail_count,
	output int          pending
);
	typedef struct {
		logic [2:0]  row;
		logic [2:0]  col;
		logic [34:0] sum;
		logic        last;
		logic        err;
	} product_t;

	product_t           product_q[$];
	logic signed [15:0] lhs_mem[64];
	logic signed [15:0] rhs_mem[64];
	logic [3:0]         lhs_rows, lhs_cols, rhs_rows, rhs_cols;
	logic               lhs_trans, rhs_trans;

	function automatic void predict_product();
		int          m, k, kr, n;
		logic [34:0] acc;
		longint      term;
		product_t    p;
		m  = lhs_trans ? lhs_cols : lhs_rows;
		k  = lhs_trans ? lhs_rows : lhs_cols;
		kr = rhs_trans ? rhs_cols : rhs_rows;
		n  = rhs_trans ? rhs_rows : rhs_cols;
		if (m == 0 || k == 0 || n == 0 || k != kr || lhs_rows > 8 || lhs_cols > 8 ||
				rhs_rows > 8 || rhs_cols > 8 || m * n > mmt_pkg::RESULT_LIMIT) begin
			p = '{row: 3'd0, col: 3'd0, sum: 35'd0, last: 1'b1, err: 1'b1};
			product_q.push_back(p);
			return;
		end
		for (int i = 0; i < m; i++) begin
			for (int j = 0; j < n; j++) begin
				acc = '0;
				for (int t = 0; t < k; t++) begin
					term = longint'(lhs_mem[lhs_trans ? t * 8 + i : i * 8 + t]) *
						longint'(rhs_mem[rhs_trans ? j * 8 + t : t * 8 + j]);
					acc = acc + term[34:0];
				end
				p = '{row: i[2:0], col: j[2:0], sum: acc,
					last: (i == m - 1 && j == n - 1), err: 1'b0};
				product_q.push_back(p);
			end
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		logic [1:0] cmd;
		logic [2:0] r, c;
		product_t   exp_p;
		if (!arst_n) begin
			for (int a = 0; a < 64; a++) begin
				lhs_mem[a] = '0;
				rhs_mem[a] = '0;
			end
			{lhs_rows, lhs_cols, rhs_rows, rhs_cols} = '0;
			lhs_trans  = 1'b0;
			rhs_trans  = 1'b0;
			fail_count = 0;
			product_q.delete();
			pending    = 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (product_q.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("unexpected result transfer: tdata=%h", m_axis_tdata);
				end else begin
					exp_p = product_q.pop_front();
					if (m_axis_tdata[2:0] !== exp_p.row || m_axis_tdata[5:3] !== exp_p.col ||
							m_axis_tdata[40:6] !== exp_p.sum || m_axis_tlast !== exp_p.last ||
							m_axis_tuser !== exp_p.err) begin
						fail_count++;
						if (fail_count <= 10)
							$display("result differs: exp row %0d col %0d sum %h last %b err %b,",
								exp_p.row, exp_p.col, exp_p.sum, exp_p.last, exp_p.err,
								" got row %0d col %0d sum %h last %b err %b",
								m_axis_tdata[2:0], m_axis_tdata[5:3], m_axis_tdata[40:6],
								m_axis_tlast, m_axis_tuser);
					end
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					mmt_pkg::REG_LEFT_ROWS:  lhs_rows  = cfg_data;
					mmt_pkg::REG_LEFT_COLS:  lhs_cols  = cfg_data;
					mmt_pkg::REG_RIGHT_ROWS: rhs_rows  = cfg_data;
					mmt_pkg::REG_RIGHT_COLS: rhs_cols  = cfg_data;
					mmt_pkg::REG_TRANS_L:    lhs_trans = cfg_data[0];
					mmt_pkg::REG_TRANS_R:    rhs_trans = cfg_data[0];
					default: ;
				endcase
			end
			if (s_axis_tvalid && s_axis_tready) begin
				cmd = s_axis_tdata[1:0];
				r   = s_axis_tdata[4:2];
				c   = s_axis_tdata[7:5];
				if (cmd == mmt_pkg::CMD_LOAD_L) begin
					if (r < lhs_rows && c < lhs_cols)
						lhs_mem[r * 8 + c] = s_axis_tdata[23:8];
				end else if (cmd == mmt_pkg::CMD_LOAD_R) begin
					if (r < rhs_rows && c < rhs_cols)
						rhs_mem[r * 8 + c] = s_axis_tdata[23:8];
				end else if (cmd == mmt_pkg::CMD_START) begin
					predict_product();
				end
			end
			pending = product_q.size();
		end
	end
endmodule

// ===== test/matrix_multiply_with_transpose_top_tb.sv =====
`timescale 1ns / 1ps
module matrix_multiply_with_transpose_top_tb;
	localparam logic [1:0] CMD_UNUSED = 2'd3;
	localparam int WATCHDOG_LIMIT = 20000;
	localparam int SETTLE_CYCLES  = 24;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [23:0] s_axis_tdata;   // cmd[1:0], row[4:2], col[7:5], value[23:8]
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [47:0] m_axis_tdata;   // out_row[2:0], out_col[5:3], sum[40:6], zeros
	logic        m_axis_tlast;
	logic        m_axis_tuser;   // error
	logic        cfg_valid;
	logic        cfg_ready;
	logic [2:0]  cfg_index;
	logic [3:0]  cfg_data;
	int          fail_count;
	int          pending;
	int          send_idle_pct, recv_idle_pct;
	int          item_count;
	int          quiet_cycles;

	matrix_multiply_with_transpose_top u_top (.*);
	mmt_checker u_checker (.*);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk)
		m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);

	// Watchdog on cycles without any transfer.
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
				(cfg_valid && cfg_ready) || !arst_n)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("matrix_multiply_with_transpose_top: mismatch");
			$finish;
		end
	end

	task automatic send_item(logic [1:0] cmd, int r, int c, logic [15:0] value);
		if ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {value, c[2:0], r[2:0], cmd};
		do @(posedge clk); while (!s_axis_tready);
		item_count++;
	endtask

	// Stop sending and let every outstanding result arrive.
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [2:0] index, int data);
		cfg_valid <= 1'b1;
		cfg_index <= index;
		cfg_data  <= data[3:0];
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic set_shape(int lr, int lc, int rr, int rc, int tl, int tr);
		write_reg(mmt_pkg::REG_LEFT_ROWS, lr);
		write_reg(mmt_pkg::REG_LEFT_COLS, lc);
		write_reg(mmt_pkg::REG_RIGHT_ROWS, rr);
		write_reg(mmt_pkg::REG_RIGHT_COLS, rc);
		write_reg(mmt_pkg::REG_TRANS_L, tl);
		write_reg(mmt_pkg::REG_TRANS_R, tr);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [15:0] pick_value();
		case ($urandom_range(9))
			0: return 16'h7FFF;
			1: return 16'h8000;
			2: return 16'h0000;
			default: return 16'($urandom_range(65535));
		endcase
	endfunction

	// One load-and-multiply pass with a random shape, then a full drain.
	task automatic run_pass();
		int m, k, n, tl, tr, lr, lc, rr, rc, loads, sel;
		logic [1:0] cmd;
		tl = $urandom_range(1);
		tr = $urandom_range(1);
		if ($urandom_range(9) == 0) begin
			m = 8; k = 8; n = 8;
		end else begin
			m = $urandom_range(1, 4); k = $urandom_range(1, 4); n = $urandom_range(1, 4);
		end
		lr = tl ? k : m;  lc = tl ? m : k;
		rr = tr ? n : k;  rc = tr ? k : n;
		// Now and then a random shape, which the block may have to reject.
		if ($urandom_range(9) == 0) begin
			lr = $urandom_range(8); lc = $urandom_range(8);
			rr = $urandom_range(8); rc = $urandom_range(8);
		end
		set_shape(lr, lc, rr, rc, tl, tr);
		loads = (lr * lc + rr * rc) * 3 / 4 + 2;
		for (int a = 0; a < loads; a++) begin
			sel = $urandom_range(99);
			cmd = (sel < 47) ? mmt_pkg::CMD_LOAD_L : (sel < 94) ? mmt_pkg::CMD_LOAD_R :
				(sel < 97) ? CMD_UNUSED : mmt_pkg::CMD_START;
			if ($urandom_range(99) < 85) begin
				if (cmd == mmt_pkg::CMD_LOAD_R)
					send_item(cmd, $urandom_range(rr ? rr - 1 : 0), $urandom_range(rc ? rc - 1 : 0),
						pick_value());
				else
					send_item(cmd, $urandom_range(lr ? lr - 1 : 0), $urandom_range(lc ? lc - 1 : 0),
						pick_value());
			end else begin
				send_item(cmd, $urandom_range(7), $urandom_range(7), pick_value());
			end
		end
		send_item(mmt_pkg::CMD_START, $urandom_range(7), $urandom_range(7), pick_value());
		drain();
	endtask

	initial begin
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		m_axis_tready = 1'b0;
		cfg_valid     = 1'b0;
		cfg_index     = '0;
		cfg_data      = '0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		item_count    = 0;
		quiet_cycles  = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: extreme values, each command, out-of-range loads and bad shapes.
		set_shape(2, 2, 2, 2, 0, 0);
		send_item(mmt_pkg::CMD_LOAD_L, 0, 0, 16'h7FFF);
		send_item(mmt_pkg::CMD_LOAD_L, 0, 1, 16'h8000);
		send_item(mmt_pkg::CMD_LOAD_L, 1, 1, 16'h8000);
		send_item(mmt_pkg::CMD_LOAD_L, 7, 7, 16'h1234);
		send_item(mmt_pkg::CMD_LOAD_R, 0, 0, 16'h8000);
		send_item(mmt_pkg::CMD_LOAD_R, 1, 0, 16'h8000);
		send_item(mmt_pkg::CMD_LOAD_R, 1, 1, 16'h7FFF);
		send_item(mmt_pkg::CMD_LOAD_R, 2, 0, 16'hFFFF);
		send_item(CMD_UNUSED, 7, 7, 16'hFFFF);
		send_item(mmt_pkg::CMD_START, 0, 0, 16'h0000);
		drain();
		set_shape(2, 2, 2, 2, 1, 1);
		send_item(mmt_pkg::CMD_START, 0, 0, 16'h0000);
		drain();
		set_shape(0, 2, 2, 2, 0, 0);
		send_item(mmt_pkg::CMD_START, 0, 0, 16'h0000);
		drain();
		set_shape(2, 3, 2, 2, 0, 1);
		send_item(mmt_pkg::CMD_START, 0, 0, 16'h0000);
		drain();
		set_shape(8, 8, 8, 8, 0, 0);
		for (int a = 0; a < 8; a++)
			send_item(mmt_pkg::CMD_LOAD_L, a, 7 - a, 16'h8000);
		send_item(mmt_pkg::CMD_LOAD_R, 7, 7, 16'h8000);
		send_item(mmt_pkg::CMD_START, 0, 0, 16'h0000);
		drain();

		send_idle_pct = 25; recv_idle_pct = 75;
		while (item_count < 170) run_pass();
		send_idle_pct = 75; recv_idle_pct = 25;
		while (item_count < 330) run_pass();
		send_idle_pct = 0;  recv_idle_pct = 0;
		while (item_count < 480) run_pass();

		if (fail_count == 0 && pending == 0)
			$display("matrix_multiply_with_transpose_top: match");
		else
			$display("matrix_multiply_with_transpose_top: mismatch");
		$finish;
	end
endmodule
